// ===== src/pwrcd_pkg.sv =====
// shared types, constants and helpers for the pulse width remote code decoder
// no dependencies

package pwrcd_pkg;

  // widths of the stream fields and configuration registers
  localparam int DUR_W   = 17;
  localparam int TIME_W  = 16;
  localparam int CODE_W  = 32;
  localparam int CNT_W   = 6;
  localparam int STAT_W  = 2;
  localparam int CFG_AW  = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = STAT_W + CODE_W + CNT_W;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SHORT_TIME  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LONG_TIME   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TOLERANCE   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_CODE_LENGTH = 2'd3;

  // configuration reset values
  localparam logic [TIME_W-1:0] SHORT_TIME_RST  = 16'd430;
  localparam logic [TIME_W-1:0] LONG_TIME_RST   = 16'd870;
  localparam logic [TIME_W-1:0] TOLERANCE_RST   = 16'd200;
  localparam logic [CNT_W-1:0]  CODE_LENGTH_RST = 6'd9;

  // result status codes
  localparam logic [STAT_W-1:0] ST_CODE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_CODE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABORT   = 2'd2;

  // one result transaction
  typedef struct packed {
    logic [CNT_W-1:0]  code_bits;
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
  } result_t;

  // mag within target +/- tol, low bound clamped at zero by moving tol across
  function automatic logic in_window(input logic [DUR_W-1:0] mag,
                                     input logic [TIME_W-1:0] target,
                                     input logic [TIME_W-1:0] tol);
    logic [DUR_W:0] lhs;
    logic [DUR_W:0] hi;
    lhs = {1'b0, mag} + {2'b00, tol};
    hi  = {2'b00, target} + {2'b00, tol};
    return (lhs >= {2'b00, target}) && ({1'b0, mag} <= hi);
  endfunction

endpackage

// ===== src/pulse_width_remote_code_decoder.sv =====
// pulse width remote code decoder, top level
// classifies pulse/gap pairs into bits and emits a code or a status per capture
// depends on pwrcd_pkg
// path to out_tvalid: input register, then result register
// throughput: one sample per cycle while the result register is empty or taken;
// an input register, then one decode step into the result register, with the
// capture state updated in the same step
// reset (rst_n low, synchronous): both stages empty, configuration at defaults,
// no capture open until a sample flagged as first arrives

module pulse_width_remote_code_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pwrcd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [16:0] duration, rest zero
  input  logic                                in_tuser,   // [0] first_sample
  input  logic                                in_tlast,   // last_sample
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pwrcd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [1:0] status, [33:2] code,
                                                          // [39:34] code_bits
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pwrcd_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [pwrcd_pkg::TIME_W-1:0]        cfg_wdata
);
  import pwrcd_pkg::*;

  // configuration registers
  logic [TIME_W-1:0] short_time_r, long_time_r, tolerance_r;
  logic [CNT_W-1:0]  code_length_r;

  // input stage
  logic              s1_valid_r;
  logic [DUR_W-1:0]  s1_dur_r;
  logic              s1_first_r, s1_last_r;

  // capture state
  logic              have_pulse_r, have_pulse_nxt;
  logic [TIME_W-1:0] held_pulse_r, held_pulse_nxt;
  logic [CODE_W-1:0] shift_bits_r, shift_bits_nxt;
  logic [CNT_W-1:0]  bits_seen_r, bits_seen_nxt;
  logic              capture_done_r, capture_done_nxt;
  logic              at_start_r, at_start_nxt;

  // result stage
  logic              out_valid_r;
  result_t           out_data_r;

  logic              s1_adv;
  logic              res_valid;
  result_t           res;
  logic [CNT_W-1:0]  target_len;
  logic [DUR_W-1:0]  gap_mag;
  logic [DUR_W-1:0]  pulse_mag;
  logic              is_zero, is_one;
  logic [CNT_W-1:0]  bits_inc;

  // handshake: input stage moves whenever the result register can take a result
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_time_r  <= SHORT_TIME_RST;
      long_time_r   <= LONG_TIME_RST;
      tolerance_r   <= TOLERANCE_RST;
      code_length_r <= CODE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHORT_TIME:  short_time_r  <= cfg_wdata;
        REG_LONG_TIME:   long_time_r   <= cfg_wdata;
        REG_TOLERANCE:   tolerance_r   <= cfg_wdata;
        REG_CODE_LENGTH: code_length_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_dur_r   <= in_tdata[DUR_W-1:0];
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // effective code length, out of range values mean full width
  always_comb begin
    if (code_length_r == '0 || code_length_r > CNT_W'(CODE_W)) begin
      target_len = CNT_W'(CODE_W);
    end else begin
      target_len = code_length_r;
    end
  end

  // pair classification on held pulse and current gap magnitude
  assign gap_mag   = s1_dur_r[DUR_W-1] ? (DUR_W'(0) - s1_dur_r) : s1_dur_r;
  assign pulse_mag = {1'b0, held_pulse_r};
  assign is_zero   = in_window(pulse_mag, short_time_r, tolerance_r) &&
                     in_window(gap_mag, long_time_r, tolerance_r);
  assign is_one    = in_window(pulse_mag, long_time_r, tolerance_r) &&
                     in_window(gap_mag, short_time_r, tolerance_r);

  // decode step for one sample
  always_comb begin
    have_pulse_nxt   = have_pulse_r;
    held_pulse_nxt   = held_pulse_r;
    shift_bits_nxt   = shift_bits_r;
    bits_seen_nxt    = bits_seen_r;
    capture_done_nxt = capture_done_r;
    at_start_nxt     = at_start_r;
    res_valid        = 1'b0;
    res.status       = ST_NO_CODE;
    res.code         = '0;
    res.code_bits    = '0;
    bits_inc         = '0;

    // first sample reopens the capture
    if (s1_first_r) begin
      capture_done_nxt = 1'b0;
      have_pulse_nxt   = 1'b0;
      held_pulse_nxt   = '0;
      shift_bits_nxt   = '0;
      bits_seen_nxt    = '0;
      at_start_nxt     = 1'b1;
    end

    if (!capture_done_nxt) begin
      if (!have_pulse_nxt) begin
        // pulse position
        at_start_nxt = 1'b0;
        if (s1_last_r) begin
          res_valid  = 1'b1;
          res.status = ST_NO_CODE;
        end else if (s1_dur_r[DUR_W-1]) begin
          if (!at_start_nxt && !(s1_first_r || at_start_r)) begin
            res_valid  = 1'b1;
            res.status = ST_ABORT;
          end
        end else begin
          held_pulse_nxt = s1_dur_r[TIME_W-1:0];
          have_pulse_nxt = 1'b1;
        end
      end else begin
        // gap position, have_pulse is only set here without a first flag
        have_pulse_nxt = 1'b0;
        bits_inc       = bits_seen_r + CNT_W'(1);
        if (is_zero) begin
          shift_bits_nxt = {shift_bits_r[CODE_W-2:0], 1'b0};
          bits_seen_nxt  = bits_inc;
        end else if (is_one) begin
          shift_bits_nxt = {shift_bits_r[CODE_W-2:0], 1'b1};
          bits_seen_nxt  = bits_inc;
        end else begin
          shift_bits_nxt = '0;
          bits_seen_nxt  = '0;
        end
        if (bits_seen_nxt >= target_len) begin
          res_valid     = 1'b1;
          res.status    = ST_CODE;
          res.code      = shift_bits_nxt;
          res.code_bits = bits_seen_nxt;
        end else if (s1_last_r) begin
          res_valid  = 1'b1;
          res.status = ST_NO_CODE;
        end
      end
      if (res_valid) begin
        capture_done_nxt = 1'b1;
      end
    end
  end

  // capture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_pulse_r   <= 1'b0;
      held_pulse_r   <= '0;
      shift_bits_r   <= '0;
      bits_seen_r    <= '0;
      capture_done_r <= 1'b1;
      at_start_r     <= 1'b0;
    end else if (s1_adv) begin
      have_pulse_r   <= have_pulse_nxt;
      held_pulse_r   <= held_pulse_nxt;
      shift_bits_r   <= shift_bits_nxt;
      bits_seen_r    <= bits_seen_nxt;
      capture_done_r <= capture_done_nxt;
      at_start_r     <= at_start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
